// File: hdl/zls_pkg.sv
`default_nettype none

package zls_pkg;

    // Depth of the queue between the parser and the output stage.
    localparam int QUEUE_DEPTH = 4;

    // A local file header is thirty bytes long; the first four are the signature.
    localparam int HEADER_LEN = 30;
    localparam int SIG_LEN    = 4;

    // Result kinds.
    localparam logic KIND_ENTRY   = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    // Stop reasons carried by the summary.
    localparam logic [1:0] REASON_CLEAN     = 2'd0;
    localparam logic [1:0] REASON_BAD_SIG   = 2'd1;
    localparam logic [1:0] REASON_TRUNC_HDR = 2'd2;
    localparam logic [1:0] REASON_TRUNC_DAT = 2'd3;

    // One record per byte that causes results: an entry, a summary, or both.
    typedef struct packed {
        logic        has_entry;
        logic        has_summary;
        logic [31:0] entry_number;
        logic [15:0] method;
        logic [31:0] stored_size;
        logic [31:0] original_size;
        logic [47:0] data_start;
        logic [31:0] entry_count;
        logic [63:0] total_compressed;
        logic [63:0] total_uncompressed;
        logic [1:0]  stop_reason;
    } record_t;

    // Expected signature byte at each of the first four header positions.
    function automatic logic [7:0] sig_byte(input logic [1:0] pos);
        logic [7:0] b;
        unique case (pos)
            2'd0:    b = 8'h50;
            2'd1:    b = 8'h4B;
            2'd2:    b = 8'h03;
            default: b = 8'h04;
        endcase
        return b;
    endfunction

endpackage

`default_nettype wire

// File: hdl/zls_front.sv
`default_nettype none

module zls_front (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire logic [7:0]       byte_value,
    input  wire logic             end_of_archive,
    input  wire logic             queue_full,
    output logic                  push,
    output zls_pkg::record_t      push_rec
);

    localparam logic [1:0] PHASE_HEADER = 2'd0;
    localparam logic [1:0] PHASE_SKIP   = 2'd1;
    localparam logic [1:0] PHASE_STOP   = 2'd2;

    localparam logic [4:0]  LAST_POS   = 5'(zls_pkg::HEADER_LEN - 1);
    localparam logic [4:0]  SIG_END    = 5'(zls_pkg::SIG_LEN);
    localparam logic [47:0] OFFSET_MAX = '1;

    logic [1:0]  phase_reg, phase_next;
    logic [4:0]  pos_reg, pos_next;
    logic [32:0] skip_reg, skip_next;
    logic [47:0] offset_reg, offset_next;
    logic [31:0] entries_reg, entries_next;
    logic [63:0] sum_c_reg, sum_c_next;
    logic [63:0] sum_u_reg, sum_u_next;

    logic [15:0] method_reg, method_next;
    logic [31:0] comp_reg, comp_next;
    logic [31:0] uncomp_reg, uncomp_next;
    logic [15:0] name_reg, name_next;
    logic [15:0] extra_reg, extra_next;

    logic        accept;
    logic        hdr_done;
    logic [1:0]  byte_sel;
    logic [15:0] extra_full;
    logic [16:0] name_extra;
    logic [32:0] skip_total;
    logic [48:0] off_sum;
    logic [64:0] sum_c_wide;
    logic [64:0] sum_u_wide;
    logic [32:0] skip_dec;
    logic [1:0]  reason;

    assign in_ready = !queue_full;
    assign accept   = in_valid && in_ready;
    assign push     = accept && (hdr_done || end_of_archive);

    // Byte lane within a four-byte size field; both size fields start at a
    // position whose low bits are two.
    assign byte_sel   = pos_reg[1:0] - 2'd2;
    assign extra_full = {byte_value, extra_reg[7:0]};
    assign name_extra = {1'b0, name_reg} + {1'b0, extra_full};
    assign skip_total = {16'd0, name_extra} + {1'b0, comp_reg};
    assign off_sum    = {1'b0, offset_reg} + {32'd0, name_extra} + 49'd1;
    assign sum_c_wide = {1'b0, sum_c_reg} + {33'd0, comp_reg};
    assign sum_u_wide = {1'b0, sum_u_reg} + {33'd0, uncomp_reg};
    assign skip_dec   = (skip_reg != 33'd0) ? (skip_reg - 33'd1) : 33'd0;

    always_comb
    begin
        phase_next   = phase_reg;
        pos_next     = pos_reg;
        skip_next    = skip_reg;
        offset_next  = offset_reg;
        entries_next = entries_reg;
        sum_c_next   = sum_c_reg;
        sum_u_next   = sum_u_reg;
        method_next  = method_reg;
        comp_next    = comp_reg;
        uncomp_next  = uncomp_reg;
        name_next    = name_reg;
        extra_next   = extra_reg;
        hdr_done     = 1'b0;
        reason       = zls_pkg::REASON_CLEAN;

        if (accept)
        begin
            unique case (phase_reg)
                PHASE_HEADER:
                begin
                    if (pos_reg < SIG_END && byte_value != zls_pkg::sig_byte(pos_reg[1:0]))
                    begin
                        phase_next = PHASE_STOP;
                        pos_next   = 5'd0;
                    end
                    else
                    begin
                        unique case (pos_reg) inside
                            5'd8:            method_next[7:0]             = byte_value;
                            5'd9:            method_next[15:8]            = byte_value;
                            [5'd18:5'd21]:   comp_next[{byte_sel, 3'b000} +: 8]   = byte_value;
                            [5'd22:5'd25]:   uncomp_next[{byte_sel, 3'b000} +: 8] = byte_value;
                            5'd26:           name_next[7:0]               = byte_value;
                            5'd27:           name_next[15:8]              = byte_value;
                            5'd28:           extra_next[7:0]              = byte_value;
                            5'd29:           extra_next[15:8]             = byte_value;
                            default:         ;
                        endcase

                        if (pos_reg == LAST_POS)
                        begin
                            hdr_done     = 1'b1;
                            entries_next = (entries_reg == '1) ? entries_reg
                                                               : entries_reg + 32'd1;
                            sum_c_next   = sum_c_wide[64] ? '1 : sum_c_wide[63:0];
                            sum_u_next   = sum_u_wide[64] ? '1 : sum_u_wide[63:0];
                            pos_next     = 5'd0;
                            skip_next    = skip_total;
                            phase_next   = (skip_total != 33'd0) ? PHASE_SKIP : PHASE_HEADER;
                        end
                        else
                        begin
                            pos_next = pos_reg + 5'd1;
                        end
                    end
                end
                PHASE_SKIP:
                begin
                    skip_next = skip_dec;
                    if (skip_dec == 33'd0)
                    begin
                        phase_next = PHASE_HEADER;
                    end
                end
                PHASE_STOP:
                begin
                end
                default:
                begin
                    phase_next = PHASE_HEADER;
                end
            endcase

            offset_next = (offset_reg == OFFSET_MAX) ? OFFSET_MAX : offset_reg + 48'd1;
        end

        if (phase_next == PHASE_STOP)
        begin
            reason = zls_pkg::REASON_BAD_SIG;
        end
        else if (phase_next == PHASE_SKIP)
        begin
            reason = zls_pkg::REASON_TRUNC_DAT;
        end
        else if (pos_next != 5'd0)
        begin
            reason = zls_pkg::REASON_TRUNC_HDR;
        end

        push_rec.has_entry          = hdr_done;
        push_rec.has_summary        = end_of_archive;
        push_rec.entry_number       = entries_reg;
        push_rec.method             = method_next;
        push_rec.stored_size        = comp_reg;
        push_rec.original_size      = uncomp_reg;
        push_rec.data_start         = off_sum[48] ? OFFSET_MAX : off_sum[47:0];
        push_rec.entry_count        = entries_next;
        push_rec.total_compressed   = sum_c_next;
        push_rec.total_uncompressed = sum_u_next;
        push_rec.stop_reason        = reason;

        // The final byte of an archive returns the scan to its starting state.
        if (accept && end_of_archive)
        begin
            phase_next   = PHASE_HEADER;
            pos_next     = 5'd0;
            skip_next    = 33'd0;
            offset_next  = 48'd0;
            entries_next = 32'd0;
            sum_c_next   = 64'd0;
            sum_u_next   = 64'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PHASE_HEADER;
            pos_reg     <= 5'd0;
            skip_reg    <= 33'd0;
            offset_reg  <= 48'd0;
            entries_reg <= 32'd0;
            sum_c_reg   <= 64'd0;
            sum_u_reg   <= 64'd0;
        end
        else
        begin
            phase_reg   <= phase_next;
            pos_reg     <= pos_next;
            skip_reg    <= skip_next;
            offset_reg  <= offset_next;
            entries_reg <= entries_next;
            sum_c_reg   <= sum_c_next;
            sum_u_reg   <= sum_u_next;
        end
    end

    // Header fields are always rewritten before an entry uses them.
    always_ff @(posedge clk)
    begin
        method_reg <= method_next;
        comp_reg   <= comp_next;
        uncomp_reg <= uncomp_next;
        name_reg   <= name_next;
        extra_reg  <= extra_next;
    end

endmodule

`default_nettype wire

// File: hdl/zls_queue.sv
`default_nettype none

module zls_queue #(
    parameter int DEPTH = zls_pkg::QUEUE_DEPTH
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire zls_pkg::record_t  push_rec,
    output logic                   full,
    input  wire logic              pop,
    output logic                   empty,
    output zls_pkg::record_t       head_rec
);

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);

    zls_pkg::record_t  slot_reg [DEPTH];
    logic [IDX_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [IDX_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign head_rec = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_IDX) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_IDX) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_rec;
        end
    end

`ifndef SYNTHESIS
    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("record pushed into a full queue");

    a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !empty)
        else $error("record popped from an empty queue");

    a_count_tracks_push: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> count_reg == $past(count_reg) + 1'b1)
        else $error("queue fill count did not follow a push");
`endif

endmodule

`default_nettype wire

// File: hdl/zls_back.sv
`default_nettype none

module zls_back (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              queue_empty,
    input  wire zls_pkg::record_t  head_rec,
    output logic                   pop,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic                   kind,
    output logic                   last_of_run,
    output logic [31:0]            entry_number,
    output logic [15:0]            method,
    output logic [31:0]            stored_size,
    output logic [31:0]            original_size,
    output logic [47:0]            data_start,
    output logic [31:0]            entry_count,
    output logic [63:0]            total_compressed,
    output logic [63:0]            total_uncompressed,
    output logic [1:0]             stop_reason
);

    logic        out_valid_reg, out_valid_next;
    logic        entry_done_reg, entry_done_next;
    logic        load;
    logic        take;
    logic        show_entry;

    logic        kind_reg;
    logic        last_reg;
    logic [31:0] index_reg;
    logic [15:0] method_reg;
    logic [31:0] comp_reg;
    logic [31:0] uncomp_reg;
    logic [47:0] offset_reg;
    logic [31:0] count_reg;
    logic [63:0] total_c_reg;
    logic [63:0] total_u_reg;
    logic [1:0]  reason_reg;

    assign load       = !out_valid_reg || out_ready;
    assign take       = load && !queue_empty;
    assign show_entry = head_rec.has_entry && !entry_done_reg;
    // A record that holds both an entry and a summary stays at the head until
    // its summary has been loaded into the output register as well.
    assign pop        = take && !(show_entry && head_rec.has_summary);

    always_comb
    begin
        out_valid_next  = load ? !queue_empty : out_valid_reg;
        entry_done_next = entry_done_reg;
        if (take)
        begin
            entry_done_next = show_entry && head_rec.has_summary;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            entry_done_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            entry_done_reg <= entry_done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            count_reg   <= head_rec.entry_count;
            total_c_reg <= head_rec.total_compressed;
            total_u_reg <= head_rec.total_uncompressed;
            if (show_entry)
            begin
                kind_reg   <= zls_pkg::KIND_ENTRY;
                last_reg   <= !head_rec.has_summary;
                index_reg  <= head_rec.entry_number;
                method_reg <= head_rec.method;
                comp_reg   <= head_rec.stored_size;
                uncomp_reg <= head_rec.original_size;
                offset_reg <= head_rec.data_start;
                reason_reg <= zls_pkg::REASON_CLEAN;
            end
            else
            begin
                kind_reg   <= zls_pkg::KIND_SUMMARY;
                last_reg   <= 1'b1;
                index_reg  <= 32'd0;
                method_reg <= 16'd0;
                comp_reg   <= 32'd0;
                uncomp_reg <= 32'd0;
                offset_reg <= 48'd0;
                reason_reg <= head_rec.stop_reason;
            end
        end
    end

    assign out_valid          = out_valid_reg;
    assign kind               = kind_reg;
    assign last_of_run        = last_reg;
    assign entry_number       = index_reg;
    assign method             = method_reg;
    assign stored_size        = comp_reg;
    assign original_size      = uncomp_reg;
    assign data_start         = offset_reg;
    assign entry_count        = count_reg;
    assign total_compressed   = total_c_reg;
    assign total_uncompressed = total_u_reg;
    assign stop_reason        = reason_reg;

`ifndef SYNTHESIS
    a_summary_follows_entry: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && kind == zls_pkg::KIND_ENTRY && !last_of_run)
        |=> (out_valid && kind == zls_pkg::KIND_SUMMARY))
        else $error("entry on the final byte was not followed by its summary");
`endif

endmodule

`default_nettype wire

// File: hdl/zip_local_header_scanner.sv
`default_nettype none

// ZIP local header scanner. Archive bytes enter one item per cycle on the
// in_valid/in_ready channel, with end_of_archive marking the final byte. The
// block walks the chain of thirty-byte local file headers, each opening with
// the PK 03 04 signature, skipping the name, extra field and data of every
// entry. A complete header gives an entry result; the final byte gives a
// summary with the entry count, saturating size totals and a stop reason
// (clean end, bad signature, truncated header or truncated data), after which
// the block is ready for a new archive. A byte that completes a header and
// is also the final byte gives two results, the entry first. The parser
// takes one byte every cycle; it stops only when its record queue is full,
// which happens when results are produced faster than the output side
// drains them (one result per cycle) or when out_ready is held low. The
// queue holds DEPTH records between parser and output register, so the
// input keeps flowing while a finished result waits to be taken.
module zip_local_header_scanner #(
    parameter int DEPTH = zls_pkg::QUEUE_DEPTH
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  byte_value,
    input  wire logic        end_of_archive,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic             kind,
    output logic             last_of_run,
    output logic [31:0]      entry_number,
    output logic [15:0]      method,
    output logic [31:0]      stored_size,
    output logic [31:0]      original_size,
    output logic [47:0]      data_start,
    output logic [31:0]      entry_count,
    output logic [63:0]      total_compressed,
    output logic [63:0]      total_uncompressed,
    output logic [1:0]       stop_reason
);

    // Records from the parser: each carries an entry, a summary or both.
    logic              push;
    logic              pop;
    logic              queue_full;
    logic              queue_empty;
    zls_pkg::record_t  push_rec;
    zls_pkg::record_t  head_rec;

    // Front: signature check, field capture, skip counting and the running
    // count and totals.
    zls_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .byte_value     (byte_value),
        .end_of_archive (end_of_archive),
        .queue_full     (queue_full),
        .push           (push),
        .push_rec       (push_rec)
    );

    // Short queue so that the parser and the output side stall independently.
    zls_queue #(
        .DEPTH (DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_rec (push_rec),
        .full     (queue_full),
        .pop      (pop),
        .empty    (queue_empty),
        .head_rec (head_rec)
    );

    // Back: unpacks each record into one or two results held in the output
    // register.
    zls_back u_back (
        .clk                (clk),
        .rst_n              (rst_n),
        .queue_empty        (queue_empty),
        .head_rec           (head_rec),
        .pop                (pop),
        .out_valid          (out_valid),
        .out_ready          (out_ready),
        .kind               (kind),
        .last_of_run        (last_of_run),
        .entry_number       (entry_number),
        .method             (method),
        .stored_size        (stored_size),
        .original_size      (original_size),
        .data_start         (data_start),
        .entry_count        (entry_count),
        .total_compressed   (total_compressed),
        .total_uncompressed (total_uncompressed),
        .stop_reason        (stop_reason)
    );

endmodule

`default_nettype wire

// File: verif/zip_local_header_scanner_test.sv
module zip_local_header_scanner_test;
    timeunit 1ns;
    timeprecision 1ps;

    // The local file header signature, first byte in the lowest lane.
    localparam logic [31:0] SIGNATURE = 32'h04034B50;

    // Cycles in which neither channel moves an item before the run is abandoned.
    // The slowest correct run never comes close: sender gaps and receiver
    // stalls are geometric at 59 per cent, and the drain pauses keep results moving.
    localparam int STALL_LIMIT = 2000;

    // Random bytes offered in each of the four idling phases.
    localparam int BYTES_PER_PHASE = 410;

    // Where the walk through the header chain currently stands.
    typedef enum logic [1:0] {
        SCAN_HEADER,
        SCAN_SKIP,
        SCAN_STOPPED
    } scan_phase_t;

    // One result item as it leaves the block.
    typedef struct packed {
        logic        kind;
        logic        last_of_run;
        logic [31:0] entry_number;
        logic [15:0] method;
        logic [31:0] stored_size;
        logic [31:0] original_size;
        logic [47:0] data_start;
        logic [31:0] entry_count;
        logic [63:0] total_compressed;
        logic [63:0] total_uncompressed;
        logic [1:0]  stop_reason;
    } scan_result_t;

    // The checker keeps its own copy of the scanner's state. Every accepted
    // byte is walked through it, and whatever results the byte should cause
    // are queued; every result item that the block hands over is then held
    // against the oldest of them.
    class header_chain_checker_t;
        scan_result_t awaited_results[$];
        int           mismatches;

        scan_phase_t  phase;
        logic [4:0]   hdr_pos;
        logic [15:0]  held_method;
        logic [31:0]  held_comp;
        logic [31:0]  held_uncomp;
        logic [15:0]  held_name;
        logic [15:0]  held_extra;
        logic [32:0]  skip_left;
        logic [47:0]  offset;
        logic [31:0]  entries;
        logic [63:0]  sum_comp;
        logic [63:0]  sum_uncomp;
        logic [1:0]   stop_code;

        function new();
            mismatches = 0;
            clear();
        endfunction

        function void clear();
            phase       = SCAN_HEADER;
            hdr_pos     = '0;
            held_method = '0;
            held_comp   = '0;
            held_uncomp = '0;
            held_name   = '0;
            held_extra  = '0;
            skip_left   = '0;
            offset      = '0;
            entries     = '0;
            sum_comp    = '0;
            sum_uncomp  = '0;
            stop_code   = zls_pkg::REASON_CLEAN;
        endfunction

        function logic [63:0] add_sat64(logic [63:0] a, logic [63:0] b);
            logic [64:0] s;
            s = {1'b0, a} + {1'b0, b};
            return s[64] ? '1 : s[63:0];
        endfunction

        function logic [47:0] add_sat48(logic [47:0] a, logic [47:0] b);
            logic [48:0] s;
            s = {1'b0, a} + {1'b0, b};
            return s[48] ? '1 : s[47:0];
        endfunction

        // Advances the copy of the state by one archive byte and queues the
        // results that the byte causes: an entry, a summary, or both.
        function void walk_byte(logic [7:0] b, logic last);
            logic [47:0]  here;
            logic [16:0]  name_extra;
            logic [1:0]   why;
            scan_result_t r;
            here = offset;
            if (phase == SCAN_HEADER) begin
                if (hdr_pos < zls_pkg::SIG_LEN && b != SIGNATURE[8 * hdr_pos[1:0] +: 8]) begin
                    phase     = SCAN_STOPPED;
                    stop_code = zls_pkg::REASON_BAD_SIG;
                    hdr_pos   = '0;
                end
                if (phase == SCAN_HEADER) begin
                    // Multi-byte fields are little-endian, so each byte is shifted
                    // in from the top and the first one ends up lowest.
                    case (hdr_pos)
                        5'd8, 5'd9:                  held_method = {b, held_method[15:8]};
                        5'd18, 5'd19, 5'd20, 5'd21: held_comp   = {b, held_comp[31:8]};
                        5'd22, 5'd23, 5'd24, 5'd25: held_uncomp = {b, held_uncomp[31:8]};
                        5'd26, 5'd27:                held_name   = {b, held_name[15:8]};
                        5'd28, 5'd29:                held_extra  = {b, held_extra[15:8]};
                        default: ;
                    endcase
                    if (hdr_pos == zls_pkg::HEADER_LEN - 1) begin
                        name_extra          = {1'b0, held_name} + {1'b0, held_extra};
                        r                   = '0;
                        r.kind              = zls_pkg::KIND_ENTRY;
                        r.last_of_run       = !last;
                        r.entry_number      = entries;
                        if (entries != '1)
                            entries = entries + 32'd1;
                        sum_comp            = add_sat64(sum_comp, {32'd0, held_comp});
                        sum_uncomp          = add_sat64(sum_uncomp, {32'd0, held_uncomp});
                        r.method            = held_method;
                        r.stored_size       = held_comp;
                        r.original_size     = held_uncomp;
                        r.data_start        = add_sat48(here, {31'd0, name_extra} + 48'd1);
                        r.entry_count       = entries;
                        r.total_compressed  = sum_comp;
                        r.total_uncompressed = sum_uncomp;
                        r.stop_reason       = zls_pkg::REASON_CLEAN;
                        awaited_results.push_back(r);
                        hdr_pos   = '0;
                        skip_left = {16'd0, name_extra} + {1'b0, held_comp};
                        phase     = (skip_left != 0) ? SCAN_SKIP : SCAN_HEADER;
                    end else begin
                        hdr_pos = hdr_pos + 5'd1;
                    end
                end
            end else if (phase == SCAN_SKIP) begin
                if (skip_left != 0)
                    skip_left = skip_left - 33'd1;
                if (skip_left == 0)
                    phase = SCAN_HEADER;
            end
            offset = add_sat48(here, 48'd1);

            if (last) begin
                if (phase == SCAN_STOPPED)
                    why = stop_code;
                else if (phase == SCAN_SKIP)
                    why = zls_pkg::REASON_TRUNC_DAT;
                else if (hdr_pos != 0)
                    why = zls_pkg::REASON_TRUNC_HDR;
                else
                    why = zls_pkg::REASON_CLEAN;
                r                    = '0;
                r.kind               = zls_pkg::KIND_SUMMARY;
                r.last_of_run        = 1'b1;
                r.entry_count        = entries;
                r.total_compressed   = sum_comp;
                r.total_uncompressed = sum_uncomp;
                r.stop_reason        = why;
                awaited_results.push_back(r);
                clear();
            end
        endfunction

        task report_mismatch(string msg);
            mismatches++;
            $display("[%0t] mismatch: %s", $time, msg);
        endtask

        task compare_field(string name, logic [63:0] got, logic [63:0] want);
            if (got !== want)
                report_mismatch($sformatf("%s is %0h, expected %0h", name, got, want));
        endtask

        task check_result(scan_result_t got);
            scan_result_t want;
            if (awaited_results.size() == 0) begin
                report_mismatch("result item arrived with none outstanding");
                return;
            end
            want = awaited_results.pop_front();
            compare_field("kind", got.kind, want.kind);
            compare_field("last_of_run", got.last_of_run, want.last_of_run);
            compare_field("entry_number", got.entry_number, want.entry_number);
            compare_field("method", got.method, want.method);
            compare_field("stored_size", got.stored_size, want.stored_size);
            compare_field("original_size", got.original_size, want.original_size);
            compare_field("data_start", got.data_start, want.data_start);
            compare_field("entry_count", got.entry_count, want.entry_count);
            compare_field("total_compressed", got.total_compressed, want.total_compressed);
            compare_field("total_uncompressed", got.total_uncompressed,
                          want.total_uncompressed);
            compare_field("stop_reason", got.stop_reason, want.stop_reason);
        endtask
    endclass

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  byte_value;
    logic        end_of_archive;
    logic        out_valid;
    logic        out_ready;
    logic        kind;
    logic        last_of_run;
    logic [31:0] entry_number;
    logic [15:0] method;
    logic [31:0] stored_size;
    logic [31:0] original_size;
    logic [47:0] data_start;
    logic [31:0] entry_count;
    logic [63:0] total_compressed;
    logic [63:0] total_uncompressed;
    logic [1:0]  stop_reason;

    header_chain_checker_t sb;

    // Bytes of the archive about to be offered, in file order.
    logic [7:0] archive_bytes[$];

    // Chance, in per cent, that the sender idles or the receiver stalls in a cycle.
    int unsigned sender_idle_pct;
    int unsigned receiver_stall_pct;

    int unsigned idle_cycles;

    zip_local_header_scanner dut (
        .clk                (clk),
        .rst_n              (rst_n),
        .in_valid           (in_valid),
        .in_ready           (in_ready),
        .byte_value         (byte_value),
        .end_of_archive     (end_of_archive),
        .out_valid          (out_valid),
        .out_ready          (out_ready),
        .kind               (kind),
        .last_of_run        (last_of_run),
        .entry_number       (entry_number),
        .method             (method),
        .stored_size        (stored_size),
        .original_size      (original_size),
        .data_start         (data_start),
        .entry_count        (entry_count),
        .total_compressed   (total_compressed),
        .total_uncompressed (total_uncompressed),
        .stop_reason        (stop_reason)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Method values lean towards the extremes and the common deflate code.
    function automatic logic [15:0] pick_method();
        case ($urandom_range(0, 3))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2:       return 16'd8;
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    function automatic logic [31:0] pick_wide();
        case ($urandom_range(0, 3))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // Appends a full thirty-byte local header carrying the given fields; the
    // version, flags, time, date and CRC bytes are random.
    function automatic void push_header(logic [15:0] m, logic [31:0] c, logic [31:0] u,
                                        logic [15:0] n, logic [15:0] x);
        for (int i = 0; i < 4; i++)
            archive_bytes.push_back(SIGNATURE[8 * i +: 8]);
        repeat (4) archive_bytes.push_back(8'($urandom_range(0, 255)));
        archive_bytes.push_back(m[7:0]);
        archive_bytes.push_back(m[15:8]);
        repeat (8) archive_bytes.push_back(8'($urandom_range(0, 255)));
        for (int i = 0; i < 4; i++)
            archive_bytes.push_back(c[8 * i +: 8]);
        for (int i = 0; i < 4; i++)
            archive_bytes.push_back(u[8 * i +: 8]);
        archive_bytes.push_back(n[7:0]);
        archive_bytes.push_back(n[15:8]);
        archive_bytes.push_back(x[7:0]);
        archive_bytes.push_back(x[15:8]);
    endfunction

    // A complete, well-formed entry. Sizes are kept small so that the data is
    // actually walked; about half the entries have no name or extra field,
    // and a quarter have no data, so headers with nothing to skip are common.
    function automatic void push_entry();
        logic [15:0] n;
        logic [15:0] x;
        logic [31:0] c;
        n = ($urandom_range(0, 1) == 0) ? 16'd0 : 16'($urandom_range(1, 6));
        x = ($urandom_range(0, 1) == 0) ? 16'd0 : 16'($urandom_range(1, 3));
        c = ($urandom_range(0, 3) == 0) ? 32'd0 : 32'($urandom_range(1, 20));
        push_header(pick_method(), c, pick_wide(), n, x);
        repeat (n + x + c) archive_bytes.push_back(8'($urandom_range(0, 255)));
    endfunction

    // Builds one archive: a few well-formed entries, then one of several
    // endings - a clean end, a cut inside a header, a cut inside the skipped
    // part, or a corrupted signature followed by bytes the scanner ignores.
    function automatic void build_archive();
        int unsigned entries_wanted;
        int unsigned ending;
        int unsigned cut;
        logic [15:0] n;
        logic [15:0] x;
        logic [31:0] c;
        archive_bytes.delete();
        entries_wanted = $urandom_range(0, 3);
        ending         = $urandom_range(0, 4);
        repeat (entries_wanted) push_entry();
        case (ending)
            0, 1:
            begin
                if (entries_wanted == 0)
                    push_entry();
            end
            2:
            begin
                // Keep between one and twenty-nine bytes of a good header.
                push_header(pick_method(), pick_wide(), pick_wide(),
                            16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
                repeat ($urandom_range(1, 29)) void'(archive_bytes.pop_back());
            end
            3:
            begin
                // Sizes far beyond what follows, so the archive ends mid-data.
                c = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF : ($urandom | 32'h100);
                n = ($urandom_range(0, 2) == 0) ? 16'hFFFF : 16'($urandom_range(0, 65535));
                x = ($urandom_range(0, 2) == 0) ? 16'hFFFF : 16'($urandom_range(0, 65535));
                push_header(pick_method(), c, pick_wide(), n, x);
                repeat ($urandom_range(0, 12))
                    archive_bytes.push_back(8'($urandom_range(0, 255)));
            end
            default:
            begin
                cut = $urandom_range(0, 3);
                push_header(16'd0, 32'd0, 32'd0, 16'd0, 16'd0);
                repeat (29 - cut) void'(archive_bytes.pop_back());
                archive_bytes[archive_bytes.size() - 1] ^= 8'($urandom_range(1, 255));
                repeat ($urandom_range(0, 5))
                    archive_bytes.push_back(8'($urandom_range(0, 255)));
            end
        endcase
    endfunction

    // Offers one byte. Idle cycles are inserted first at the sender's rate;
    // once raised, in_valid and the payload hold until the item is taken.
    // in_ready is read straight after the rising edge, before the block's own
    // updates for that edge have landed.
    task automatic send_byte(logic [7:0] b, logic eoa);
        while ($urandom_range(0, 99) < sender_idle_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid       = 1'b1;
        byte_value     = b;
        end_of_archive = eoa;
        do
            @(posedge clk);
        while (!in_ready);
        sb.walk_byte(b, eoa);
        @(negedge clk);
    endtask

    task automatic send_archive();
        for (int i = 0; i < archive_bytes.size(); i++)
            send_byte(archive_bytes[i], i == archive_bytes.size() - 1);
    endtask

    // Holds the sender back until every outstanding result has been taken.
    task automatic drain_results();
        in_valid = 1'b0;
        while (sb.awaited_results.size() != 0)
            @(negedge clk);
    endtask

    // The receiver decides at each falling edge whether it will take a result.
    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            out_ready = rst_n && ($urandom_range(0, 99) >= receiver_stall_pct);
        end
    end

    // Result items are sampled at the rising edge at which they are taken.
    initial
    begin
        scan_result_t got;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && out_ready)
            begin
                got.kind               = kind;
                got.last_of_run        = last_of_run;
                got.entry_number       = entry_number;
                got.method             = method;
                got.stored_size        = stored_size;
                got.original_size      = original_size;
                got.data_start         = data_start;
                got.entry_count        = entry_count;
                got.total_compressed   = total_compressed;
                got.total_uncompressed = total_uncompressed;
                got.stop_reason        = stop_reason;
                sb.check_result(got);
            end
        end
    end

    // Watchdog: a long run of cycles in which nothing moves on either channel
    // means the block has hung.
    initial
    begin
        idle_cycles = 0;
        forever
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    initial
    begin
        int unsigned offered;
        sb                 = new();
        rst_n              = 1'b0;
        in_valid           = 1'b0;
        byte_value         = 8'h00;
        end_of_archive     = 1'b0;
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Short archives that end early. A lone all-ones byte is a bad
        // signature on the final byte; a lone P, and PK 03, are cut-off headers.
        archive_bytes = {8'hFF};
        send_archive();
        archive_bytes = {8'h50};
        send_archive();
        archive_bytes = {8'h50, 8'h4B, 8'h03};
        send_archive();
        // The signature broken at its second byte, with later bytes ignored.
        archive_bytes = {8'h50, 8'h00, 8'hAA, 8'h55};
        send_archive();
        // Broken at the third byte, and at the fourth on the final byte itself.
        archive_bytes = {8'h50, 8'h4B, 8'h04};
        send_archive();
        archive_bytes = {8'h50, 8'h4B, 8'h03, 8'h05};
        send_archive();
        // A zero first byte, then a P that must not restart the scan.
        archive_bytes = {8'h00, 8'hFF, 8'h50};
        send_archive();

        // Random archives under four idling regimes. Between regimes the
        // sender waits for every result to come back.
        for (int regime = 0; regime < 4; regime++)
        begin
            case (regime)
                0:       begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
                1:       begin sender_idle_pct = 59; receiver_stall_pct = 0;  end
                2:       begin sender_idle_pct = 0;  receiver_stall_pct = 59; end
                default: begin sender_idle_pct = 31; receiver_stall_pct = 31; end
            endcase
            offered = 0;
            while (offered < BYTES_PER_PHASE)
            begin
                build_archive();
                send_archive();
                offered += archive_bytes.size();
            end
            drain_results();
        end

        // Wait for any stray result before the final check.
        repeat (8) @(posedge clk);
        if (sb.awaited_results.size() != 0)
            sb.report_mismatch($sformatf("%0d expected results never arrived",
                                         sb.awaited_results.size()));
        if (sb.mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
